@@ rtl/uart_transceiver_with_echo_core_defines.svh @@
// Assertion macros used by the checker of the UART transceiver.
`ifndef UART_TRANSCEIVER_WITH_ECHO_CORE_DEFINES_SVH
`define UART_TRANSCEIVER_WITH_ECHO_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ute_pkg.sv @@
`default_nettype none

package ute_pkg;

  localparam int DATA_BITS       = 8;
  localparam int TIMER_WIDTH     = 16;
  localparam int RX_TIMER_WIDTH  = TIMER_WIDTH + 1;
  localparam int BIT_INDEX_WIDTH = 4;

  localparam logic [TIMER_WIDTH-1:0] BIT_PERIOD_RESET = TIMER_WIDTH'(1666);

  localparam logic [DATA_BITS-1:0] ECHO_ON_CODE  = DATA_BITS'(8'h05);
  localparam logic [DATA_BITS-1:0] ECHO_OFF_CODE = DATA_BITS'(8'h06);

  // APB register map: one 32-bit word per register
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam logic REG_IDX_BIT_PERIOD = 1'b0;

  typedef struct packed {
    logic                 rx_line;
    logic                 send_valid;
    logic [DATA_BITS-1:0] send_byte;
  } in_item_t;

  typedef struct packed {
    logic                 tx_line;
    logic                 send_accepted;
    logic                 recv_valid;
    logic [DATA_BITS-1:0] recv_byte;
    logic                 echo_active;
    logic                 tx_busy;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/ute_core.sv @@
`default_nettype none

module ute_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                advance,
  input  wire logic [ute_pkg::TIMER_WIDTH-1:0]     bit_period,
  input  wire ute_pkg::in_item_t                   in_item,
  output ute_pkg::out_item_t                       result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SAMPLE,
    PH_REARM
  } rx_phase_t;

  logic [ute_pkg::TIMER_WIDTH-1:0]     tx_timer, tx_timer_next;
  logic [ute_pkg::BIT_INDEX_WIDTH-1:0] tx_bit_index, tx_bit_index_next;
  logic [ute_pkg::DATA_BITS-1:0]       tx_shift, tx_shift_next;
  logic                                tx_active, tx_active_next;
  logic                                tx_level, tx_level_next;
  logic [ute_pkg::RX_TIMER_WIDTH-1:0]  rx_timer, rx_timer_next;
  logic [ute_pkg::BIT_INDEX_WIDTH-1:0] rx_bit_index, rx_bit_index_next;
  logic [ute_pkg::DATA_BITS-1:0]       rx_shift, rx_shift_next;
  rx_phase_t                           rx_phase, rx_phase_next;
  logic                                echo_on, echo_on_next;
  logic                                echo_pending, echo_pending_next;
  logic [ute_pkg::DATA_BITS-1:0]       echo_byte, echo_byte_next;

  logic [ute_pkg::TIMER_WIDTH-1:0]     period;
  logic [ute_pkg::TIMER_WIDTH-1:0]     period_m1;
  logic [ute_pkg::RX_TIMER_WIDTH-1:0]  period_x15;
  logic [ute_pkg::RX_TIMER_WIDTH-1:0]  rx_timer_dec;
  logic                                got;
  logic [ute_pkg::DATA_BITS-1:0]       word;
  logic                                accepted;

  // zero period runs as one tick per bit
  assign period     = (bit_period == '0) ? ute_pkg::TIMER_WIDTH'(1) : bit_period;
  assign period_m1  = period - ute_pkg::TIMER_WIDTH'(1);
  assign period_x15 = {1'b0, period} + {2'b0, period[ute_pkg::TIMER_WIDTH-1:1]};

  always_comb begin
    rx_timer_next     = rx_timer;
    rx_bit_index_next = rx_bit_index;
    rx_shift_next     = rx_shift;
    rx_phase_next     = rx_phase;
    echo_on_next      = echo_on;
    echo_pending_next = echo_pending;
    echo_byte_next    = echo_byte;
    tx_timer_next     = tx_timer;
    tx_bit_index_next = tx_bit_index;
    tx_shift_next     = tx_shift;
    tx_active_next    = tx_active;
    tx_level_next     = tx_level;
    got               = 1'b0;
    word              = '0;
    accepted          = 1'b0;

    rx_timer_dec = (rx_timer != '0) ? rx_timer - ute_pkg::RX_TIMER_WIDTH'(1) : rx_timer;

    // receiver
    case (rx_phase)
      PH_SAMPLE: begin
        rx_timer_next = rx_timer_dec;
        if (rx_timer_dec == '0) begin
          rx_shift_next     = {in_item.rx_line, rx_shift[ute_pkg::DATA_BITS-1:1]};
          rx_bit_index_next = rx_bit_index + ute_pkg::BIT_INDEX_WIDTH'(1);
          rx_timer_next     = {1'b0, period};
          if (rx_bit_index_next >= ute_pkg::BIT_INDEX_WIDTH'(ute_pkg::DATA_BITS)) begin
            got           = 1'b1;
            word          = rx_shift_next;
            rx_phase_next = PH_REARM;
          end
        end
      end
      PH_REARM: begin
        rx_timer_next = rx_timer_dec;
        if (rx_timer_dec == '0) begin
          rx_phase_next = PH_IDLE;
        end
      end
      default: begin
        rx_phase_next = PH_IDLE;
        if (!in_item.rx_line) begin
          rx_phase_next     = PH_SAMPLE;
          rx_timer_next     = period_x15;
          rx_bit_index_next = '0;
          rx_shift_next     = '0;
        end
      end
    endcase

    // echo decision uses the mode from before this word's code
    if (got) begin
      if (echo_on) begin
        echo_pending_next = 1'b1;
        echo_byte_next    = word;
      end
      if (word == ute_pkg::ECHO_ON_CODE) begin
        echo_on_next = 1'b1;
      end
      if (word == ute_pkg::ECHO_OFF_CODE) begin
        echo_on_next = 1'b0;
      end
    end

    // transmitter
    if (tx_active) begin
      if (tx_timer != '0) begin
        tx_timer_next = tx_timer - ute_pkg::TIMER_WIDTH'(1);
      end else begin
        tx_bit_index_next = tx_bit_index + ute_pkg::BIT_INDEX_WIDTH'(1);
        if (tx_bit_index_next <= ute_pkg::BIT_INDEX_WIDTH'(ute_pkg::DATA_BITS)) begin
          tx_level_next = tx_shift[0];
          tx_shift_next = {1'b0, tx_shift[ute_pkg::DATA_BITS-1:1]};
          tx_timer_next = period_m1;
        end else if (tx_bit_index_next ==
                     ute_pkg::BIT_INDEX_WIDTH'(ute_pkg::DATA_BITS + 1)) begin
          tx_level_next = 1'b1;
          tx_timer_next = period_m1;
        end else begin
          tx_active_next    = 1'b0;
          tx_bit_index_next = '0;
          tx_level_next     = 1'b1;
        end
      end
    end

    // idle transmitter starts a frame in the same tick; echo goes first
    if (!tx_active_next) begin
      if (echo_pending_next) begin
        echo_pending_next = 1'b0;
        tx_active_next    = 1'b1;
        tx_shift_next     = echo_byte_next;
        tx_bit_index_next = '0;
        tx_level_next     = 1'b0;
        tx_timer_next     = period_m1;
      end else if (in_item.send_valid) begin
        accepted          = 1'b1;
        tx_active_next    = 1'b1;
        tx_shift_next     = in_item.send_byte;
        tx_bit_index_next = '0;
        tx_level_next     = 1'b0;
        tx_timer_next     = period_m1;
      end
    end

    result.tx_line       = tx_level_next;
    result.send_accepted = accepted;
    result.recv_valid    = got;
    result.recv_byte     = word;
    result.echo_active   = echo_on_next;
    result.tx_busy       = tx_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_timer     <= '0;
      tx_bit_index <= '0;
      tx_shift     <= '0;
      tx_active    <= 1'b0;
      tx_level     <= 1'b1;
      rx_timer     <= '0;
      rx_bit_index <= '0;
      rx_shift     <= '0;
      rx_phase     <= PH_IDLE;
      echo_on      <= 1'b0;
      echo_pending <= 1'b0;
      echo_byte    <= '0;
    end else if (advance) begin
      tx_timer     <= tx_timer_next;
      tx_bit_index <= tx_bit_index_next;
      tx_shift     <= tx_shift_next;
      tx_active    <= tx_active_next;
      tx_level     <= tx_level_next;
      rx_timer     <= rx_timer_next;
      rx_bit_index <= rx_bit_index_next;
      rx_shift     <= rx_shift_next;
      rx_phase     <= rx_phase_next;
      echo_on      <= echo_on_next;
      echo_pending <= echo_pending_next;
      echo_byte    <= echo_byte_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/uart_transceiver_with_echo_core.sv @@
// 8N1 UART transceiver with receive echo. Every input transaction is one sample
// tick: the receive pin level plus an optional host byte to send. Every tick
// yields exactly one result transaction carrying the transmit pin level, whether
// the host byte was taken, any byte received on that tick, the echo mode and the
// transmitter busy flag. The block takes one tick per clock while the result
// side does not stall: a transaction lands in an input register, and the whole
// UART state update runs combinationally between that register and the result
// register. Throughput is one tick per clock without stall, set by the state
// update loop; an empty input register still takes the next tick while a
// result waits under stall. Bit timing is programmed through APB register 0
// (bit_period, ticks per bit, reset 1666); write it only while no tick is in
// flight. Byte 0x05 received turns echo on, 0x06 turns it off, and while echo is
// on each received byte is sent back ahead of host bytes.
`default_nettype none

module uart_transceiver_with_echo_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,

  // tick input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 rx_line,
  input  wire logic                                 send_valid,
  input  wire logic [ute_pkg::DATA_BITS-1:0]        send_byte,

  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      tx_line,
  output logic                                      send_accepted,
  output logic                                      recv_valid,
  output logic [ute_pkg::DATA_BITS-1:0]             recv_byte,
  output logic                                      echo_active,
  output logic                                      tx_busy,

  // APB configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [ute_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  wire logic [ute_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [ute_pkg::APB_DATA_WIDTH-1:0]        prdata,
  output logic                                      pready
);

  logic [ute_pkg::TIMER_WIDTH-1:0] bit_period;
  logic                            reg_idx;
  logic                            cfg_write;

  logic                            in_reg_valid;
  ute_pkg::in_item_t               in_reg;
  logic                            res_valid;
  ute_pkg::out_item_t              res_reg;
  ute_pkg::out_item_t              result;

  logic                            res_free;
  logic                            advance;
  logic                            in_take;

  // Register file: the word index sits above the byte offset bits.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ute_pkg::APB_ADDR_WIDTH-1];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= ute_pkg::BIT_PERIOD_RESET;
    end else if (cfg_write && (reg_idx == ute_pkg::REG_IDX_BIT_PERIOD)) begin
      bit_period <= pwdata[ute_pkg::TIMER_WIDTH-1:0];
    end
  end

  // Read back the period; the word beyond the map reads as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == ute_pkg::REG_IDX_BIT_PERIOD) begin
      prdata = {{(ute_pkg::APB_DATA_WIDTH-ute_pkg::TIMER_WIDTH){1'b0}}, bit_period};
    end
  end

  // Pipeline control: the result register frees up when it is empty or its
  // transaction leaves this cycle. The held tick advances into it then, and
  // the input register refills in the same cycle, so a tick per clock flows.
  assign res_free = !res_valid || !out_stall;
  assign advance  = in_reg_valid && res_free;
  assign in_stall = in_reg_valid && !res_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  // Hold the tick payload until it advances.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg.rx_line    <= rx_line;
      in_reg.send_valid <= send_valid;
      in_reg.send_byte  <= send_byte;
    end
  end

  // UART state update: commits only when the held tick advances.
  ute_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .bit_period (bit_period),
    .in_item    (in_reg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Load a fresh result only on advance; a stalled result holds.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= result;
    end
  end

  assign out_valid     = res_valid;
  assign tx_line       = res_reg.tx_line;
  assign send_accepted = res_reg.send_accepted;
  assign recv_valid    = res_reg.recv_valid;
  assign recv_byte     = res_reg.recv_byte;
  assign echo_active   = res_reg.echo_active;
  assign tx_busy       = res_reg.tx_busy;

endmodule

`default_nettype wire

@@ rtl/ute_checker.sv @@
`default_nettype none

`include "uart_transceiver_with_echo_core_defines.svh"

module ute_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          tx_line,
  input wire logic                          send_accepted,
  input wire logic                          recv_valid,
  input wire logic [ute_pkg::DATA_BITS-1:0] recv_byte,
  input wire logic                          tx_busy
);

  // a stalled result stays put
  `UTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tx_line) && $stable(send_accepted) && $stable(recv_valid) && $stable(recv_byte) && $stable(tx_busy), "stalled result changed")

  // no received byte means a zero byte field
  `UTE_ASSERT_NOW(a_recv_zero, out_valid && !recv_valid, recv_byte == '0, "recv_byte set without recv_valid")

  // a taken host byte starts a frame with the start bit
  `UTE_ASSERT_NOW(a_accept_start, out_valid && send_accepted, tx_busy && !tx_line, "accepted byte did not start a frame")

  // an idle transmitter keeps the line high
  `UTE_ASSERT_NOW(a_idle_high, out_valid && !tx_busy, tx_line, "line low while transmitter idle")

endmodule

bind uart_transceiver_with_echo_core ute_checker u_checker (.*);

`default_nettype wire

@@ tb/uart_transceiver_with_echo_core_tb.sv @@
module uart_transceiver_with_echo_core_tb;

  // Receiver phases of the line model below.
  typedef enum logic [1:0] {RX_IDLE, RX_SAMPLE, RX_REARM} rx_state_t;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [2:0] {ROW_TICK, ROW_PERIOD, ROW_FRAME, ROW_HOLD, ROW_SETTLE} row_kind_t;

  // One directed row. ROW_TICK sends tick; when typed is set, want is the
  // result read straight off the spec instead of the line model. ROW_PERIOD
  // writes arg to bit_period. ROW_FRAME receives a whole frame of arg[7:0],
  // with host offers on random ticks when arg[8] is set. ROW_HOLD idles the
  // receive pin for arg ticks with host offers. ROW_SETTLE runs idle ticks
  // until both directions of the line are quiet.
  typedef struct packed {
    row_kind_t kind;
    logic [31:0] arg;
    ute_pkg::in_item_t tick;
    logic typed;
    ute_pkg::out_item_t want;
  } row_t;

  localparam int RANDOM_TICKS = 1300;
  localparam logic [ute_pkg::APB_ADDR_WIDTH-1:0] BIT_PERIOD_ADDR =
    ute_pkg::APB_ADDR_WIDTH'(4 * int'(ute_pkg::REG_IDX_BIT_PERIOD));

  localparam ute_pkg::in_item_t LINE_IDLE = '{rx_line: 1'b1, send_valid: 1'b0,
                                              send_byte: 8'h00};
  localparam ute_pkg::out_item_t AT_RESET = '{tx_line: 1'b1, send_accepted: 1'b0,
                                              recv_valid: 1'b0, recv_byte: 8'h00,
                                              echo_active: 1'b0, tx_busy: 1'b0};
  localparam ute_pkg::out_item_t HOST_TAKEN = '{tx_line: 1'b0, send_accepted: 1'b1,
                                                recv_valid: 1'b0, recv_byte: 8'h00,
                                                echo_active: 1'b0, tx_busy: 1'b1};
  localparam ute_pkg::out_item_t HOST_REFUSED = '{tx_line: 1'b0, send_accepted: 1'b0,
                                                  recv_valid: 1'b0, recv_byte: 8'h00,
                                                  echo_active: 1'b0, tx_busy: 1'b1};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic rx_line;
  logic send_valid;
  logic [ute_pkg::DATA_BITS-1:0] send_byte;
  logic out_valid;
  logic out_stall;
  logic tx_line;
  logic send_accepted;
  logic recv_valid;
  logic [ute_pkg::DATA_BITS-1:0] recv_byte;
  logic echo_active;
  logic tx_busy;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ute_pkg::APB_ADDR_WIDTH-1:0] paddr;
  logic [ute_pkg::APB_DATA_WIDTH-1:0] pwdata;
  logic [ute_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  uart_transceiver_with_echo_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_line(rx_line),
    .send_valid(send_valid),
    .send_byte(send_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tx_line(tx_line),
    .send_accepted(send_accepted),
    .recv_valid(recv_valid),
    .recv_byte(recv_byte),
    .echo_active(echo_active),
    .tx_busy(tx_busy),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Line model state: bit timing plus both halves of the UART and the echo slot.
  logic [ute_pkg::TIMER_WIDTH-1:0] bit_period_q;
  logic [ute_pkg::TIMER_WIDTH-1:0] tx_count;
  logic [ute_pkg::BIT_INDEX_WIDTH-1:0] tx_bit;
  logic [ute_pkg::DATA_BITS-1:0] tx_data;
  logic tx_on;
  logic tx_pin;
  logic [ute_pkg::RX_TIMER_WIDTH-1:0] rx_count;
  logic [ute_pkg::BIT_INDEX_WIDTH-1:0] rx_bit;
  logic [ute_pkg::DATA_BITS-1:0] rx_data;
  rx_state_t rx_state;
  logic echo_mode;
  logic echo_waiting;
  logic [ute_pkg::DATA_BITS-1:0] echo_data;

  // Results the line model expects, oldest first.
  ute_pkg::out_item_t tick_results[$];

  int ticks_fed;
  int results_seen;
  int mismatches;
  int calm_left;

  // Directed stimulus: reset state, host handshake, period extremes (a zero
  // after masking, 2 with junk in the upper word, a plain 3, the 16-bit maximum
  // read back with junk above it), a period change in the middle of a bit,
  // echo on and off codes, echo slot overrun and echo taking the transmitter
  // ahead of a host offer.
  row_t directed_rows [0:25] = '{
    '{ROW_TICK, 32'd0, LINE_IDLE, 1'b1, AT_RESET},
    '{ROW_PERIOD, 32'd4, '0, 1'b0, '0},
    '{ROW_TICK, 32'd0, '{1'b1, 1'b1, 8'hA5}, 1'b1, HOST_TAKEN},
    '{ROW_TICK, 32'd0, '{1'b1, 1'b1, 8'h3C}, 1'b1, HOST_REFUSED},
    '{ROW_TICK, 32'd0, '{1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{ROW_SETTLE, 32'd0, '0, 1'b0, '0},
    '{ROW_PERIOD, 32'h0001_0000, '0, 1'b0, '0},
    '{ROW_FRAME, {23'd0, 1'b1, 8'h00}, '0, 1'b0, '0},
    '{ROW_FRAME, {24'd0, ute_pkg::ECHO_ON_CODE}, '0, 1'b0, '0},
    '{ROW_FRAME, {24'd0, 8'h5A}, '0, 1'b0, '0},
    '{ROW_SETTLE, 32'd0, '0, 1'b0, '0},
    '{ROW_PERIOD, 32'd40, '0, 1'b0, '0},
    '{ROW_TICK, 32'd0, '{1'b1, 1'b1, 8'h81}, 1'b0, '0},
    '{ROW_PERIOD, 32'd1, '0, 1'b0, '0},
    '{ROW_FRAME, {24'd0, 8'h11}, '0, 1'b0, '0},
    '{ROW_FRAME, {24'd0, 8'h22}, '0, 1'b0, '0},
    '{ROW_FRAME, {23'd0, 1'b1, ute_pkg::ECHO_OFF_CODE}, '0, 1'b0, '0},
    '{ROW_HOLD, 32'd40, '0, 1'b0, '0},
    '{ROW_SETTLE, 32'd0, '0, 1'b0, '0},
    '{ROW_PERIOD, 32'h8000_0002, '0, 1'b0, '0},
    '{ROW_FRAME, {23'd0, 1'b1, 8'hFF}, '0, 1'b0, '0},
    '{ROW_PERIOD, 32'd3, '0, 1'b0, '0},
    '{ROW_FRAME, {24'd0, 8'h80}, '0, 1'b0, '0},
    '{ROW_PERIOD, 32'hFFFF_FFFF, '0, 1'b0, '0},
    '{ROW_PERIOD, 32'd4, '0, 1'b0, '0},
    '{ROW_SETTLE, 32'd0, '0, 1'b0, '0}
  };

  function automatic int unsigned ticks_per_bit();
    return (bit_period_q == '0) ? 1 : int'(bit_period_q);
  endfunction

  // Advance the line model by one sample tick: receiver first, then the echo
  // decision, then the transmitter, which may start a frame on the same tick.
  function automatic ute_pkg::out_item_t uart_tick(ute_pkg::in_item_t t);
    int unsigned p;
    ute_pkg::out_item_t r;
    logic got;
    logic [ute_pkg::DATA_BITS-1:0] word;
    logic load;
    logic [ute_pkg::DATA_BITS-1:0] load_data;
    p = ticks_per_bit();
    r = '0;
    got = 1'b0;
    word = '0;
    load = 1'b0;
    load_data = '0;

    case (rx_state)
      RX_SAMPLE: begin
        if (rx_count != '0) rx_count = rx_count - 1'b1;
        if (rx_count == '0) begin
          rx_data = {t.rx_line, rx_data[ute_pkg::DATA_BITS-1:1]};
          rx_bit = rx_bit + 1'b1;
          rx_count = ute_pkg::RX_TIMER_WIDTH'(p);
          if (rx_bit >= ute_pkg::BIT_INDEX_WIDTH'(ute_pkg::DATA_BITS)) begin
            got = 1'b1;
            word = rx_data;
            rx_state = RX_REARM;
          end
        end
      end
      RX_REARM: begin
        if (rx_count != '0) rx_count = rx_count - 1'b1;
        if (rx_count == '0) rx_state = RX_IDLE;
      end
      default: begin
        rx_state = RX_IDLE;
        if (!t.rx_line) begin
          rx_state = RX_SAMPLE;
          rx_count = ute_pkg::RX_TIMER_WIDTH'(p + p / 2);
          rx_bit = '0;
          rx_data = '0;
        end
      end
    endcase

    // The echo decision uses the mode from before this word's own code.
    if (got) begin
      if (echo_mode) begin
        echo_waiting = 1'b1;
        echo_data = word;
      end
      if (word == ute_pkg::ECHO_ON_CODE) echo_mode = 1'b1;
      if (word == ute_pkg::ECHO_OFF_CODE) echo_mode = 1'b0;
    end

    if (tx_on) begin
      if (tx_count != '0) begin
        tx_count = tx_count - 1'b1;
      end else begin
        tx_bit = tx_bit + 1'b1;
        if (tx_bit <= ute_pkg::BIT_INDEX_WIDTH'(ute_pkg::DATA_BITS)) begin
          tx_pin = tx_data[0];
          tx_data = tx_data >> 1;
          tx_count = ute_pkg::TIMER_WIDTH'(p - 1);
        end else if (tx_bit == ute_pkg::BIT_INDEX_WIDTH'(ute_pkg::DATA_BITS + 1)) begin
          tx_pin = 1'b1;
          tx_count = ute_pkg::TIMER_WIDTH'(p - 1);
        end else begin
          tx_on = 1'b0;
          tx_bit = '0;
          tx_pin = 1'b1;
        end
      end
    end

    // A pending echo wins the idle transmitter; the host must offer again.
    if (!tx_on) begin
      if (echo_waiting) begin
        echo_waiting = 1'b0;
        load = 1'b1;
        load_data = echo_data;
      end else if (t.send_valid) begin
        r.send_accepted = 1'b1;
        load = 1'b1;
        load_data = t.send_byte;
      end
    end
    if (load) begin
      tx_on = 1'b1;
      tx_data = load_data;
      tx_bit = '0;
      tx_pin = 1'b0;
      tx_count = ute_pkg::TIMER_WIDTH'(p - 1);
    end

    r.tx_line = tx_pin;
    r.recv_valid = got;
    r.recv_byte = word;
    r.echo_active = echo_mode;
    r.tx_busy = tx_on;
    return r;
  endfunction

  // Mostly short, a few long.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic ute_pkg::in_item_t line_tick(logic level, logic host);
    ute_pkg::in_item_t t;
    t.rx_line = level;
    t.send_valid = host && ($urandom_range(0, 3) != 0);
    t.send_byte = 8'($urandom);
    return t;
  endfunction

  task automatic compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d %s: expected %0h, got %0h", results_seen, what, want, got);
    end
  endtask

  // Offer one tick transaction, optionally after an idle gap, and hold it
  // until the block takes it. The expectation is queued at acceptance.
  task automatic send_tick(input ute_pkg::in_item_t t, input logic typed,
                           input ute_pkg::out_item_t want, input logic quick);
    int gap;
    ute_pkg::out_item_t pred;
    gap = 0;
    if (!quick) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 200);
      else if ($urandom_range(0, 3) == 0) gap = gap_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_line <= t.rx_line;
    send_valid <= t.send_valid;
    send_byte <= t.send_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = uart_tick(t);
    tick_results.push_back(typed ? want : pred);
    ticks_fed++;
  endtask

  task automatic feed_idle(int n, logic host);
    repeat (n) send_tick(line_tick(1'b1, host), 1'b0, '0, 1'b0);
  endtask

  // Drive a start bit, the data LSB first and a stop bit at the current
  // period; stop after nbits bits to build a broken frame.
  task automatic feed_frame(logic [ute_pkg::DATA_BITS-1:0] data, logic host, int nbits);
    logic [ute_pkg::DATA_BITS+1:0] frame;
    int unsigned p;
    frame = {1'b1, data, 1'b0};
    p = ticks_per_bit();
    for (int i = 0; i < nbits; i++)
      repeat (p) send_tick(line_tick(frame[i], host), 1'b0, '0, 1'b0);
  endtask

  // Run idle ticks without gaps until neither direction has work left.
  task automatic settle();
    while (!(rx_state == RX_IDLE && !tx_on && !echo_waiting))
      send_tick(LINE_IDLE, 1'b0, '0, 1'b1);
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tick_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [ute_pkg::APB_DATA_WIDTH-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BIT_PERIOD_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(output logic [ute_pkg::APB_DATA_WIDTH-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= BIT_PERIOD_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write bit_period between phases, then read it back; only the low
  // TIMER_WIDTH bits are held.
  task automatic set_period(logic [ute_pkg::APB_DATA_WIDTH-1:0] value);
    logic [ute_pkg::APB_DATA_WIDTH-1:0] readback;
    wait_idle();
    apb_write(value);
    bit_period_q = value[ute_pkg::TIMER_WIDTH-1:0];
    apb_read(readback);
    compare_field("bit_period readback", int'(bit_period_q),
                  int'(readback[ute_pkg::TIMER_WIDTH-1:0]));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure: runs of stall of random length, with the
  // occasional long stretch of none.
  initial begin : stall_gen
    int run;
    out_stall <= 1'b0;
    forever begin
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (gap_len()) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result transaction, field by field, against the
  // oldest expectation.
  always @(posedge clk) begin : result_check
    ute_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (tick_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want = tick_results.pop_front();
        compare_field("tx_line", want.tx_line, tx_line);
        compare_field("send_accepted", want.send_accepted, send_accepted);
        compare_field("recv_valid", want.recv_valid, recv_valid);
        compare_field("recv_byte", want.recv_byte, recv_byte);
        compare_field("echo_active", want.echo_active, echo_active);
        compare_field("tx_busy", want.tx_busy, tx_busy);
      end
    end
  end

  // Hard limit far above the slowest legal run, long bit periods included.
  initial begin : watchdog
    repeat (8_000_000) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    row_t row;
    logic [ute_pkg::APB_DATA_WIDTH-1:0] readback;
    logic [ute_pkg::DATA_BITS-1:0] data;
    int rand_start;
    int pick;
    int unsigned p;

    // Every input known from time zero.
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_line <= 1'b1;
    send_valid <= 1'b0;
    send_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    // Line model at reset.
    bit_period_q = ute_pkg::BIT_PERIOD_RESET;
    tx_count = '0;
    tx_bit = '0;
    tx_data = '0;
    tx_on = 1'b0;
    tx_pin = 1'b1;
    rx_count = '0;
    rx_bit = '0;
    rx_data = '0;
    rx_state = RX_IDLE;
    echo_mode = 1'b0;
    echo_waiting = 1'b0;
    echo_data = '0;
    ticks_fed = 0;
    results_seen = 0;
    mismatches = 0;
    calm_left = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Check the reset period before anything writes it.
    apb_read(readback);
    compare_field("bit_period at reset", int'(ute_pkg::BIT_PERIOD_RESET),
                  int'(readback[ute_pkg::TIMER_WIDTH-1:0]));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_TICK: send_tick(row.tick, row.typed, row.want, 1'b0);
        ROW_PERIOD: set_period(row.arg);
        ROW_FRAME: feed_frame(row.arg[ute_pkg::DATA_BITS-1:0], row.arg[8],
                              ute_pkg::DATA_BITS + 2);
        ROW_HOLD: feed_idle(int'(row.arg), 1'b1);
        default: settle();
      endcase
    end

    // Random phases: pick a period, then mostly well-formed frames with
    // random content and the echo codes often, some broken frames and noise.
    rand_start = ticks_fed;
    while (ticks_fed - rand_start < RANDOM_TICKS) begin
      if ($urandom_range(0, 1) == 1) settle();
      pick = $urandom_range(0, 99);
      if (pick < 5) p = 0;
      else if (pick < 25) p = $urandom_range(1, 3);
      else if (pick < 85) p = $urandom_range(4, 12);
      else p = $urandom_range(13, 40);
      set_period({16'($urandom), 16'(p)});
      p = ticks_per_bit();

      repeat ($urandom_range(3, 8)) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          if (pick < 8) data = ute_pkg::ECHO_ON_CODE;
          else if (pick < 16) data = ute_pkg::ECHO_OFF_CODE;
          else data = 8'($urandom);
          feed_frame(data, 1'($urandom_range(0, 1)), ute_pkg::DATA_BITS + 2);
          feed_idle($urandom_range(0, 2 * p), 1'($urandom_range(0, 1)));
        end else if (pick < 85) begin
          // Cut the frame short, then let the receiver recover.
          feed_frame(8'($urandom), 1'b1, $urandom_range(1, ute_pkg::DATA_BITS + 1));
          feed_idle(10 * p, 1'b0);
        end else if (pick < 93) begin
          repeat ($urandom_range(1, 4 * p))
            send_tick(line_tick(1'($urandom_range(0, 1)), 1'b1), 1'b0, '0, 1'b0);
          feed_idle(10 * p, 1'b0);
        end else begin
          feed_idle($urandom_range(1, 3 * p), 1'b1);
        end
      end
    end

    // Drain the pipeline, then report.
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && tick_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ute_pkg.sv
rtl/ute_core.sv
rtl/uart_transceiver_with_echo_core.sv
rtl/ute_checker.sv
tb/uart_transceiver_with_echo_core_tb.sv
